@@ sv/bpd_pkg.sv @@
// Shared types and constants for the button press dimmer.
// Register indexes, reset values, press word codes and the structs passed
// between the configuration registers, the update core and the top level.
`default_nettype none

package bpd_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE    = 3'd0,
		REG_SHORT_PRESS = 3'd1,
		REG_LONG_PRESS  = 3'd2,
		REG_DIM_STEP    = 3'd3,
		REG_FADE_TARGET = 3'd4
	} reg_idx_t;

	// Register reset values
	localparam logic [7:0]  DEBOUNCE_RST    = 8'd50;
	localparam logic [15:0] SHORT_PRESS_RST = 16'd500;
	localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
	localparam logic [15:0] DIM_STEP_RST    = 16'd10;
	localparam logic [7:0]  FADE_TARGET_RST = 8'd255;

	// Brightness limits
	localparam logic [7:0] LEVEL_MAX = 8'd255;
	localparam logic [7:0] LEVEL_MIN = 8'd0;

	// Press word codes
	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_CONFIRMED   = 3'd1,
		EV_SWITCH_MODE = 3'd2,
		EV_START_FADE  = 3'd3,
		EV_FADE_DONE   = 3'd4,
		EV_LONG_REL    = 3'd5
	} press_ev_t;

	// Live configuration
	typedef struct packed {
		logic [7:0]  debounce_ms;
		logic [15:0] short_press_ms;
		logic [15:0] long_press_ms;
		logic [15:0] dim_step_ms;
		logic [7:0]  fade_target;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic [7:0] level;
		press_ev_t  ev;
		logic       fade_running;
		logic       press_held;
	} result_t;

endpackage

`default_nettype wire

@@ sv/bpd_cfg_regs.sv @@
// Configuration register bank for the button press dimmer.
// Depends on bpd_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module bpd_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [bpd_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [15:0]                 wr_data,
	output bpd_pkg::cfg_t                    cfg
);

	bpd_pkg::cfg_t cfg_q;

	// Indexed write; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms    <= bpd_pkg::DEBOUNCE_RST;
			cfg_q.short_press_ms <= bpd_pkg::SHORT_PRESS_RST;
			cfg_q.long_press_ms  <= bpd_pkg::LONG_PRESS_RST;
			cfg_q.dim_step_ms    <= bpd_pkg::DIM_STEP_RST;
			cfg_q.fade_target    <= bpd_pkg::FADE_TARGET_RST;
		end else if (wr_en) begin
			case (bpd_pkg::reg_idx_t'(wr_index))
				bpd_pkg::REG_DEBOUNCE:    cfg_q.debounce_ms    <= wr_data[7:0];
				bpd_pkg::REG_SHORT_PRESS: cfg_q.short_press_ms <= wr_data;
				bpd_pkg::REG_LONG_PRESS:  cfg_q.long_press_ms  <= wr_data;
				bpd_pkg::REG_DIM_STEP:    cfg_q.dim_step_ms    <= wr_data;
				bpd_pkg::REG_FADE_TARGET: cfg_q.fade_target    <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/bpd_core.sv @@
// Press timing, release decode and dimming ramp state with its update logic.
// Depends on bpd_pkg for cfg_t, result_t and the press word codes.
`default_nettype none

module bpd_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step_en,
	input  wire logic       key_low,
	input  wire logic [7:0] elapsed_ms,
	input  wire logic       mode_is_off,
	input  bpd_pkg::cfg_t   cfg,
	output bpd_pkg::result_t result
);

	// Saturating adds
	function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	logic        pressed_q, pressed_d;
	logic [7:0]  low_time_q, low_time_d;
	logic [15:0] hold_time_q, hold_time_d;
	logic [15:0] dim_wait_q, dim_wait_d;
	logic [7:0]  level_q, level_d;
	logic        ramp_up_q, ramp_up_d;
	logic        fade_active_q, fade_active_d;
	logic        fade_done_q, fade_done_d;
	bpd_pkg::press_ev_t ev;

	// Next state for one time step
	always_comb begin
		pressed_d     = pressed_q;
		low_time_d    = low_time_q;
		hold_time_d   = hold_time_q;
		dim_wait_d    = sat_add16(dim_wait_q, elapsed_ms);
		level_d       = level_q;
		ramp_up_d     = ramp_up_q;
		fade_active_d = fade_active_q;
		fade_done_d   = fade_done_q;
		ev            = bpd_pkg::EV_NONE;

		// debounce, hold timing and release decode
		if (!pressed_q) begin
			if (key_low) begin
				// first low sample adds no time
				if (low_time_q != 8'd0 || hold_time_q != 16'd0) begin
					low_time_d  = sat_add8(low_time_q, elapsed_ms);
					hold_time_d = sat_add16(hold_time_q, elapsed_ms);
				end
				if (low_time_d >= cfg.debounce_ms) begin
					pressed_d  = 1'b1;
					low_time_d = 8'd0;
					ev         = bpd_pkg::EV_CONFIRMED;
				end
			end else begin
				low_time_d  = 8'd0;
				hold_time_d = 16'd0;
			end
		end else if (key_low) begin
			hold_time_d = sat_add16(hold_time_q, elapsed_ms);
		end else begin
			pressed_d = 1'b0;
			if (hold_time_q < cfg.short_press_ms) begin
				if (fade_active_q) begin
					level_d       = cfg.fade_target;
					fade_active_d = 1'b0;
					fade_done_d   = 1'b1;
					ev            = bpd_pkg::EV_FADE_DONE;
				end else if (!fade_done_q && mode_is_off) begin
					level_d       = bpd_pkg::LEVEL_MIN;
					fade_active_d = 1'b1;
					ev            = bpd_pkg::EV_START_FADE;
				end else begin
					fade_done_d = 1'b1;
					ev          = bpd_pkg::EV_SWITCH_MODE;
				end
			end else begin
				if (fade_active_q) begin
					fade_active_d = 1'b0;
					fade_done_d   = 1'b1;
				end
				ev = bpd_pkg::EV_LONG_REL;
			end
			hold_time_d = 16'd0;
			low_time_d  = 8'd0;
		end

		// long hold: cancel fade, step the ramp
		if (pressed_d && hold_time_d >= cfg.long_press_ms) begin
			if (fade_active_d) begin
				fade_active_d = 1'b0;
				fade_done_d   = 1'b1;
			end
			if (!mode_is_off && dim_wait_d >= cfg.dim_step_ms) begin
				dim_wait_d = 16'd0;
				if (ramp_up_q) begin
					if (level_q != bpd_pkg::LEVEL_MAX) level_d = level_q + 8'd1;
					if (level_d == bpd_pkg::LEVEL_MAX) ramp_up_d = 1'b0;
				end else begin
					if (level_q != bpd_pkg::LEVEL_MIN) level_d = level_q - 8'd1;
					if (level_d == bpd_pkg::LEVEL_MIN) ramp_up_d = 1'b1;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q     <= 1'b0;
			low_time_q    <= 8'd0;
			hold_time_q   <= 16'd0;
			dim_wait_q    <= 16'd0;
			level_q       <= 8'd0;
			ramp_up_q     <= 1'b1;
			fade_active_q <= 1'b0;
			fade_done_q   <= 1'b0;
		end else if (step_en) begin
			pressed_q     <= pressed_d;
			low_time_q    <= low_time_d;
			hold_time_q   <= hold_time_d;
			dim_wait_q    <= dim_wait_d;
			level_q       <= level_d;
			ramp_up_q     <= ramp_up_d;
			fade_active_q <= fade_active_d;
			fade_done_q   <= fade_done_d;
		end
	end

	// Result word from the post-step state
	assign result.level        = level_d;
	assign result.ev           = ev;
	assign result.fade_running = fade_active_d;
	assign result.press_held   = pressed_d;

endmodule

`default_nettype wire

@@ sv/button_press_dimmer_core.sv @@
// Top level of the button press dimmer: input register, update core, result register.
// Depends on bpd_pkg, bpd_cfg_regs and bpd_core.
//
//   channel | direction | handshake            | payload
//   in      | to block  | in_valid / in_ready  | key_low, elapsed_ms, mode_is_off
//   out     | from block| out_valid / out_ready| out_level, press_event, fade_running, press_held
//   cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while out_ready stays high; a word taken into the input register
// reaches the output through a single-pass state update into the result register.
// Reset clears the press timers, ramp state and handshake flags, and loads register defaults.
// A stalled output holds its word; an empty input register still takes a new word while the
// result waits, then holds it until the result register frees up. cfg_ready is always high.
`default_nettype none

module button_press_dimmer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic                          key_low,
	input  wire logic [7:0]                    elapsed_ms,
	input  wire logic                          mode_is_off,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [7:0]                    out_level,
	output      logic [2:0]                    press_event,
	output      logic                          fade_running,
	output      logic                          press_held,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data
);

	bpd_pkg::cfg_t    cfg;
	bpd_pkg::result_t result;
	bpd_pkg::result_t result_s2;

	logic       valid_s1;
	logic       key_s1;
	logic [7:0] elapsed_s1;
	logic       off_s1;
	logic       out_valid_q;
	logic       advance;
	logic       in_take;

	assign cfg_ready = 1'b1;

	bpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: stage 1 moves on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			key_s1     <= key_low;
			elapsed_s1 <= elapsed_ms;
			off_s1     <= mode_is_off;
		end
	end

	bpd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.key_low     (key_s1),
		.elapsed_ms  (elapsed_s1),
		.mode_is_off (off_s1),
		.cfg         (cfg),
		.result      (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_level    = result_s2.level;
	assign press_event  = result_s2.ev;
	assign fade_running = result_s2.fade_running;
	assign press_held   = result_s2.press_held;

endmodule

`default_nettype wire

@@ tb/button_press_dimmer_core_tb.sv @@
// Self-checking testbench for button_press_dimmer_core: press timing, events and dimming ramp.
// Depends on bpd_pkg and the RTL only; a behavioural predictor in this file
// forms the expected result word for every sample the block accepts.

module button_press_dimmer_core_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        key_low = 1'b0;
	logic [7:0]  elapsed_ms = 8'd0;
	logic        mode_is_off = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_level;
	logic [2:0]  press_event;
	logic        fade_running;
	logic        press_held;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index = bpd_pkg::REG_DEBOUNCE;
	logic [15:0] cfg_data = 16'd0;

	// Shared control between the test sequence and the output side
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	int   hold_left = 0;
	int   mismatch_count = 0;

	// Result words still owed by the block, oldest first
	bpd_pkg::result_t lamp_words_due[$];

	// Predictor copy of the registers
	logic [7:0]  debounce_cfg = bpd_pkg::DEBOUNCE_RST;
	logic [15:0] short_cfg = bpd_pkg::SHORT_PRESS_RST;
	logic [15:0] long_cfg = bpd_pkg::LONG_PRESS_RST;
	logic [15:0] dim_cfg = bpd_pkg::DIM_STEP_RST;
	logic [7:0]  fade_cfg = bpd_pkg::FADE_TARGET_RST;

	// Predictor copy of the press and lamp state
	logic        held = 1'b0;
	logic [7:0]  low_ms = 8'd0;
	logic [15:0] hold_ms = 16'd0;
	logic [15:0] since_step_ms = 16'd0;
	logic [7:0]  lamp_level = bpd_pkg::LEVEL_MIN;
	logic        ramping_up = 1'b1;
	logic        fading = 1'b0;
	logic        fade_over = 1'b0;

	button_press_dimmer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_low      (key_low),
		.elapsed_ms   (elapsed_ms),
		.mode_is_off  (mode_is_off),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_level    (out_level),
		.press_event  (press_event),
		.fade_running (fade_running),
		.press_held   (press_held),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic logic [7:0] sat8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	function automatic logic [15:0] sat16(input logic [15:0] a, input logic [7:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	// Step the press/lamp state by one sample and queue the word it yields
	function automatic void advance_dimmer(input logic key, input logic [7:0] el,
			input logic off);
		bpd_pkg::press_ev_t ev;
		bpd_pkg::result_t   w;
		ev = bpd_pkg::EV_NONE;
		since_step_ms = sat16(since_step_ms, el);

		if (!held) begin
			if (key) begin
				// first low sample adds no time
				if (low_ms != 0 || hold_ms != 0) begin
					low_ms = sat8(low_ms, el);
					hold_ms = sat16(hold_ms, el);
				end
				if (low_ms >= debounce_cfg) begin
					held = 1'b1;
					low_ms = 8'd0;
					ev = bpd_pkg::EV_CONFIRMED;
				end
			end else begin
				low_ms = 8'd0;
				hold_ms = 16'd0;
			end
		end else if (key) begin
			hold_ms = sat16(hold_ms, el);
		end else begin
			// release of a confirmed press
			held = 1'b0;
			if (hold_ms < short_cfg) begin
				if (fading) begin
					lamp_level = fade_cfg;
					fading = 1'b0;
					fade_over = 1'b1;
					ev = bpd_pkg::EV_FADE_DONE;
				end else if (!fade_over && off) begin
					lamp_level = bpd_pkg::LEVEL_MIN;
					fading = 1'b1;
					ev = bpd_pkg::EV_START_FADE;
				end else begin
					fade_over = 1'b1;
					ev = bpd_pkg::EV_SWITCH_MODE;
				end
			end else begin
				if (fading) begin
					fading = 1'b0;
					fade_over = 1'b1;
				end
				ev = bpd_pkg::EV_LONG_REL;
			end
			hold_ms = 16'd0;
			low_ms = 8'd0;
		end

		// long hold: cancel fade, ramp one step per dim interval
		if (held && hold_ms >= long_cfg) begin
			if (fading) begin
				fading = 1'b0;
				fade_over = 1'b1;
			end
			if (!off && since_step_ms >= dim_cfg) begin
				since_step_ms = 16'd0;
				if (ramping_up) begin
					if (lamp_level < bpd_pkg::LEVEL_MAX) lamp_level++;
					if (lamp_level == bpd_pkg::LEVEL_MAX) ramping_up = 1'b0;
				end else begin
					if (lamp_level > bpd_pkg::LEVEL_MIN) lamp_level--;
					if (lamp_level == bpd_pkg::LEVEL_MIN) ramping_up = 1'b1;
				end
			end
		end

		w.level = lamp_level;
		w.ev = ev;
		w.fade_running = fading;
		w.press_held = held;
		lamp_words_due.push_back(w);
	endfunction

	// Offer one sample, with an occasional idle gap in front of it
	task automatic send_sample(input logic key, input logic [7:0] el, input logic off);
		if (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_low <= key;
		elapsed_ms <= el;
		mode_is_off <= off;
		do @(posedge clk); while (!(in_valid && in_ready));
		advance_dimmer(key, el, off);
	endtask

	// Stop offering and wait for every owed word to come out
	task automatic settle();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (lamp_words_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (lamp_words_due.size() != 0) begin
			report_mismatch("words never delivered", lamp_words_due.size(), 0);
			lamp_words_due.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// One register write; cfg_valid is left high for a following write
	task automatic write_reg(input bpd_pkg::reg_idx_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			bpd_pkg::REG_DEBOUNCE:    debounce_cfg = data[7:0];
			bpd_pkg::REG_SHORT_PRESS: short_cfg = data;
			bpd_pkg::REG_LONG_PRESS:  long_cfg = data;
			bpd_pkg::REG_DIM_STEP:    dim_cfg = data;
			bpd_pkg::REG_FADE_TARGET: fade_cfg = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] deb, input logic [15:0] short_ms,
			input logic [15:0] long_ms, input logic [15:0] dim_ms, input logic [7:0] fade);
		settle();
		write_reg(bpd_pkg::REG_DEBOUNCE, {8'd0, deb});
		write_reg(bpd_pkg::REG_SHORT_PRESS, short_ms);
		write_reg(bpd_pkg::REG_LONG_PRESS, long_ms);
		write_reg(bpd_pkg::REG_DIM_STEP, dim_ms);
		write_reg(bpd_pkg::REG_FADE_TARGET, {8'd0, fade});
		cfg_valid <= 1'b0;
	endtask

	// Key held for a number of samples, then released; mode off may flip mid-hold
	task automatic hold_key(input int samples, input int el_lo, input int el_hi,
			input logic off);
		logic off_now;
		off_now = off;
		for (int i = 0; i < samples; i++) begin
			if ($urandom_range(19) == 0) off_now = ~off_now;
			send_sample(1'b1, 8'($urandom_range(el_hi, el_lo)), off_now);
		end
		send_sample(1'b0, 8'($urandom_range(255)), off_now);
	endtask

	task automatic noise(input int n);
		for (int i = 0; i < n; i++)
			send_sample(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// Mix of short, medium and long presses with some glitch samples between
	task automatic random_presses(input int n);
		int   sent;
		int   pick;
		int   len;
		logic off;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			off = ($urandom_range(3) == 0);
			if (pick < 12) begin
				noise(1);
				sent++;
			end else begin
				if (pick < 45) begin
					len = $urandom_range(3, 1);
					hold_key(len, 0, 60, off);
				end else if (pick < 75) begin
					len = $urandom_range(8, 2);
					hold_key(len, 0, 255, off);
				end else begin
					len = $urandom_range(25, 5);
					hold_key(len, 100, 255, off);
				end
				sent += len + 1;
			end
		end
	endtask

	// Edges of the fields, each press outcome and the named corner cases
	task automatic test_directed();
		// default debounce: a lone low sample never builds up low time
		send_sample(1'b1, 8'd255, 1'b0);
		send_sample(1'b1, 8'd255, 1'b1);
		send_sample(1'b0, 8'd0, 1'b0);
		set_config(8'd0, bpd_pkg::SHORT_PRESS_RST, bpd_pkg::LONG_PRESS_RST,
			bpd_pkg::DIM_STEP_RST, 8'd200);
		// zero debounce confirms at once; short release from off starts the fade
		send_sample(1'b1, 8'd0, 1'b1);
		send_sample(1'b1, 8'd100, 1'b1);
		send_sample(1'b0, 8'd5, 1'b1);
		// short press during the fade finishes it at the target level
		send_sample(1'b1, 8'd7, 1'b0);
		send_sample(1'b0, 8'd20, 1'b0);
		// plain short press: mode switch
		send_sample(1'b1, 8'd1, 1'b0);
		send_sample(1'b0, 8'd1, 1'b0);
		// past the short time but not the long time
		repeat (4) send_sample(1'b1, 8'd255, 1'b0);
		send_sample(1'b0, 8'd0, 1'b0);
		// long hold ramps, then mode off stops the ramp
		repeat (6) send_sample(1'b1, 8'd255, 1'b0);
		repeat (2) send_sample(1'b1, 8'd255, 1'b1);
		send_sample(1'b0, 8'd128, 1'b1);
	endtask

	task automatic test_default_presses();
		set_config(8'd0, bpd_pkg::SHORT_PRESS_RST, bpd_pkg::LONG_PRESS_RST,
			bpd_pkg::DIM_STEP_RST, bpd_pkg::LEVEL_MAX);
		random_presses(150);
	endtask

	// Shortest thresholds and zero dim interval: long holds drive the level to both ends
	task automatic test_ramp_ends();
		set_config(8'd0, 16'd1, 16'd1, 16'd0, bpd_pkg::LEVEL_MIN);
		calm = 1'b1;
		repeat (10) hold_key(52, 0, 255, 1'b0);
		calm = 1'b0;
	endtask

	// Largest thresholds: hold time and dim wait must saturate to reach them
	task automatic test_saturation();
		set_config(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, bpd_pkg::LEVEL_MAX);
		hold_key(280, 240, 255, 1'b0);
		random_presses(20);
	endtask

	// Non-zero debounce: presses never confirm, timers must keep clearing
	task automatic test_no_confirm();
		set_config(8'd255, 16'd500, 16'd1000, 16'd10, bpd_pkg::LEVEL_MIN);
		noise(60);
		set_config(8'($urandom_range(254, 1)), 16'($urandom_range(65535, 1)),
			16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
			8'($urandom_range(255)));
		noise(60);
	endtask

	// Output held off while samples keep coming, so the input side stalls
	task automatic test_backpressure();
		set_config(8'd0, 16'($urandom_range(2000, 1)), 16'($urandom_range(3000, 1)),
			16'($urandom_range(50, 1)), 8'($urandom_range(255)));
		hold_req = 1'b1;
		random_presses(150);
	endtask

	// Output side: random stalls, a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 100;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 30);
		end
	end

	// Compare each delivered word with the oldest one owed
	always @(posedge clk) begin : check_word
		bpd_pkg::result_t want;
		if (out_valid && out_ready) begin
			if (lamp_words_due.size() == 0) begin
				report_mismatch("word with none owed", out_level, 0);
			end else begin
				want = lamp_words_due.pop_front();
				if (out_level !== want.level)
					report_mismatch("out_level", out_level, want.level);
				if (press_event !== want.ev)
					report_mismatch("press_event", press_event, want.ev);
				if (fade_running !== want.fade_running)
					report_mismatch("fade_running", fade_running, want.fade_running);
				if (press_held !== want.press_held)
					report_mismatch("press_held", press_held, want.press_held);
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_default_presses();
		test_ramp_ends();
		test_saturation();
		test_no_confirm();
		test_backpressure();
		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
sv/bpd_pkg.sv
sv/bpd_cfg_regs.sv
sv/bpd_core.sv
sv/button_press_dimmer_core.sv
tb/button_press_dimmer_core_tb.sv
